// ----- hw/rtl/tdp_pkg.sv -----
// Shared types and constants for the trial division prime test block.
package tdp_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 16;
   localparam int REQ_WIDTH           = 16;
   localparam int DIVISOR_OUT_WIDTH   = 8;

   localparam logic [1:0] VERDICT_PRIME = 2'd0;
   localparam logic [1:0] VERDICT_SMALL = 2'd1;
   localparam logic [1:0] VERDICT_EVEN  = 2'd2;
   localparam logic [1:0] VERDICT_ODD   = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_CHECK,
      ST_DIVIDE,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic done;
      logic rem_zero;
   } div_status_type;

endpackage

// ----- hw/rtl/tdp_divider.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module tdp_divider #(
   parameter int VW = 16,
   parameter int DW = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [VW-1:0]           dividend,
   input  logic [DW-1:0]           divisor,
   output tdp_pkg::div_status_type status
);

   localparam int CW = (VW > 1) ? $clog2(VW) : 1;

   logic [DW-1:0] rem_ff,   rem_in;
   logic [CW-1:0] cnt_ff,   cnt_in;
   logic          busy_ff,  busy_in;
   logic          done_ff,  done_in;
   logic          zero_ff,  zero_in;
   logic [DW:0]   shifted;
   logic [DW:0]   diff;
   logic [DW-1:0] rem_next;

   always_comb begin
      shifted  = {rem_ff, dividend[cnt_ff]};
      diff     = shifted - {1'b0, divisor};
      // subtract when the partial remainder reaches the divisor
      rem_next = (shifted >= {1'b0, divisor}) ? diff[DW-1:0] : shifted[DW-1:0];

      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      if (start) begin
         rem_in  = '0;
         cnt_in  = CW'(VW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = rem_next;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            zero_in = (rem_next == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
   end

   assign status.done     = done_ff;
   assign status.rem_zero = zero_ff;

endmodule

// ----- hw/rtl/trial_division_prime_test.sv -----
// Top level of the trial division prime test block.
// From accept to rsp_valid: values below two and even values go from classify straight to
//   report; odd values go to check, and each odd divisor from three whose square fits the
//   value gets a divide run over VW = min(VALUE_WIDTH, 16) bits in the bit-serial remainder unit.
// Throughput: one word at a time; req_stall stays high until the result is in the rsp register.
// Reset: synchronous, active high; clears the sequencer and the result valid, no memories.
module trial_division_prime_test #(
   parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [tdp_pkg::REQ_WIDTH-1:0]          req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_prime_flag,
   output logic [1:0]                             rsp_verdict,
   output logic [tdp_pkg::DIVISOR_OUT_WIDTH-1:0]  rsp_smallest_divisor
);

   // Only the low 16 bits of the word carry the value, further masked by VALUE_WIDTH.
   localparam int VW  = (VALUE_WIDTH < tdp_pkg::REQ_WIDTH) ? VALUE_WIDTH : tdp_pkg::REQ_WIDTH;
   // Divisor must reach one odd step past sqrt(2^VW).
   localparam int DW  = (VW + 1) / 2 + 1;
   localparam int SQW = VW + 2;
   localparam int OW  = tdp_pkg::DIVISOR_OUT_WIDTH;

   tdp_pkg::state_type state_ff, state_in;

   logic [VW-1:0]  value_ff,   value_in;
   logic [DW-1:0]  div_ff,     div_in;      // current odd trial divisor
   logic [SQW-1:0] sq_ff,      sq_in;       // div_ff squared, kept incrementally
   logic           res_flag_ff,    res_flag_in;
   logic [1:0]     res_verdict_ff, res_verdict_in;
   logic [OW-1:0]  res_div_ff,     res_div_in;
   logic           rsp_valid_ff,   rsp_valid_in;
   logic           rsp_flag_ff,    rsp_flag_in;
   logic [1:0]     rsp_verdict_ff, rsp_verdict_in;
   logic [OW-1:0]  rsp_div_ff,     rsp_div_in;

   logic                    div_start;
   logic [DW+OW-1:0]        div_ext;
   tdp_pkg::div_status_type div_status;

   tdp_divider #(
      .VW (VW),
      .DW (DW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (value_ff),
      .divisor  (div_ff),
      .status   (div_status)
   );

   // Report only the low bits of the divisor, zero extended for narrow widths.
   assign div_ext = {{OW{1'b0}}, div_ff};

   always_comb begin
      state_in       = state_ff;
      value_in       = value_ff;
      div_in         = div_ff;
      sq_in          = sq_ff;
      res_flag_in    = res_flag_ff;
      res_verdict_in = res_verdict_ff;
      res_div_in     = res_div_ff;
      div_start      = 1'b0;

      // Drop the result word once the consumer takes it.
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_flag_in    = rsp_flag_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_div_in     = rsp_div_ff;

      case (state_ff)
         tdp_pkg::ST_IDLE: begin
            if (req_valid) begin
               value_in = req_value[VW-1:0];
               state_in = tdp_pkg::ST_CLASSIFY;
            end
         end
         tdp_pkg::ST_CLASSIFY: begin
            res_flag_in = 1'b0;
            res_div_in  = '0;
            if (value_ff < VW'(2)) begin
               res_verdict_in = tdp_pkg::VERDICT_SMALL;
               state_in       = tdp_pkg::ST_REPORT;
            end else if (!value_ff[0]) begin
               if (value_ff == VW'(2)) begin
                  res_flag_in    = 1'b1;
                  res_verdict_in = tdp_pkg::VERDICT_PRIME;
               end else begin
                  res_verdict_in = tdp_pkg::VERDICT_EVEN;
                  res_div_in     = OW'(2);
               end
               state_in = tdp_pkg::ST_REPORT;
            end else begin
               // Seed the odd divisor walk at three.
               div_in   = DW'(3);
               sq_in    = SQW'(9);
               state_in = tdp_pkg::ST_CHECK;
            end
         end
         tdp_pkg::ST_CHECK: begin
            if (sq_ff > {2'b00, value_ff}) begin
               res_flag_in    = 1'b1;
               res_verdict_in = tdp_pkg::VERDICT_PRIME;
               res_div_in     = '0;
               state_in       = tdp_pkg::ST_REPORT;
            end else begin
               div_start = 1'b1;
               state_in  = tdp_pkg::ST_DIVIDE;
            end
         end
         tdp_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               if (div_status.rem_zero) begin
                  res_flag_in    = 1'b0;
                  res_verdict_in = tdp_pkg::VERDICT_ODD;
                  res_div_in     = div_ext[OW-1:0];
                  state_in       = tdp_pkg::ST_REPORT;
               end else begin
                  // Advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4.
                  div_in   = div_ff + DW'(2);
                  sq_in    = sq_ff + SQW'({div_ff, 2'b00}) + SQW'(4);
                  state_in = tdp_pkg::ST_CHECK;
               end
            end
         end
         tdp_pkg::ST_REPORT: begin
            // Hold the result until the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_flag_in    = res_flag_ff;
               rsp_verdict_in = res_verdict_ff;
               rsp_div_in     = res_div_ff;
               state_in       = tdp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff       <= value_in;
      div_ff         <= div_in;
      sq_ff          <= sq_in;
      res_flag_ff    <= res_flag_in;
      res_verdict_ff <= res_verdict_in;
      res_div_ff     <= res_div_in;
      rsp_flag_ff    <= rsp_flag_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_div_ff     <= rsp_div_in;
   end

   // Take a new word only while the sequencer sits idle.
   assign req_stall            = (state_ff != tdp_pkg::ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_prime_flag       = rsp_flag_ff;
   assign rsp_verdict          = rsp_verdict_ff;
   assign rsp_smallest_divisor = rsp_div_ff;

endmodule

// ----- hw/rtl/tdp_checker.sv -----
// Port-level checker for the trial division prime test block, with its bind.
module tdp_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_prime_flag,
   input logic [1:0]                            rsp_verdict,
   input logic [tdp_pkg::DIVISOR_OUT_WIDTH-1:0] rsp_smallest_divisor
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block not busy after taking a word");

   a_flag_matches_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_prime_flag == (rsp_verdict == tdp_pkg::VERDICT_PRIME)))
      else $error("prime flag disagrees with verdict");

   a_even_divisor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == tdp_pkg::VERDICT_EVEN) |-> rsp_smallest_divisor == 8'd2)
      else $error("even composite without divisor two");

   a_no_divisor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_verdict == tdp_pkg::VERDICT_PRIME) ||
                    (rsp_verdict == tdp_pkg::VERDICT_SMALL)) |-> rsp_smallest_divisor == 8'd0)
      else $error("divisor reported for prime or small value");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_prime_flag       (rsp_prime_flag),
   .rsp_verdict          (rsp_verdict),
   .rsp_smallest_divisor (rsp_smallest_divisor)
);

// ----- tb/tb_trial_division_prime_test.sv -----
// Self-checking testbench for the trial division prime test block.
module tb_trial_division_prime_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_WIDTH         = tdp_pkg::REQ_WIDTH;
   localparam int DIVISOR_OUT_WIDTH = tdp_pkg::DIVISOR_OUT_WIDTH;

   // One classification as it appears on the rsp channel.
   typedef struct packed {
      logic                         prime_flag;
      logic [1:0]                   verdict;
      logic [DIVISOR_OUT_WIDTH-1:0] smallest_divisor;
   } prime_result_type;

   // A sent word and the classification it must come back with.
   typedef struct {
      logic [REQ_WIDTH-1:0] value;
      prime_result_type     want;
   } pending_query_type;

   // Directed row: the classification is typed in only where it is obvious.
   typedef struct {
      logic [REQ_WIDTH-1:0] value;
      bit                   typed;
      prime_result_type     want;
   } probe_row_type;

   localparam int PROBE_ROWS = 22;
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_CYCLES = 64;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [REQ_WIDTH-1:0]         req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_prime_flag;
   logic [1:0]                   rsp_verdict;
   logic [DIVISOR_OUT_WIDTH-1:0] rsp_smallest_divisor;

   pending_query_type pending_verdicts[$];
   int unsigned       fault_count = 0;
   int unsigned       send_idle_pct = 0;
   int unsigned       recv_stall_pct = 0;

   // Extremes, every verdict, the tiny primes that skip all trials, and odd
   // composites whose smallest factor is far out (squares and products of
   // primes just under the square root of the value range).
   probe_row_type probe_table [0:PROBE_ROWS-1] = '{
      '{16'd0,     1'b1, '{1'b0, tdp_pkg::VERDICT_SMALL, 8'd0}},
      '{16'd1,     1'b1, '{1'b0, tdp_pkg::VERDICT_SMALL, 8'd0}},
      '{16'd2,     1'b1, '{1'b1, tdp_pkg::VERDICT_PRIME, 8'd0}},
      '{16'd3,     1'b1, '{1'b1, tdp_pkg::VERDICT_PRIME, 8'd0}},
      '{16'd5,     1'b1, '{1'b1, tdp_pkg::VERDICT_PRIME, 8'd0}},
      '{16'd7,     1'b1, '{1'b1, tdp_pkg::VERDICT_PRIME, 8'd0}},
      '{16'd65535, 1'b1, '{1'b0, tdp_pkg::VERDICT_ODD,   8'd3}},
      '{16'd65534, 1'b1, '{1'b0, tdp_pkg::VERDICT_EVEN,  8'd2}},
      '{16'd4,     1'b1, '{1'b0, tdp_pkg::VERDICT_EVEN,  8'd2}},
      '{16'd9,     1'b0, '{1'b0, tdp_pkg::VERDICT_SMALL, 8'd0}},
      '{16'd25,    1'b0, '{1'b0, tdp_pkg::VERDICT_SMALL, 8'd0}},
      '{16'd49,    1'b0, '{1'b0, tdp_pkg::VERDICT_SMALL, 8'd0}},
      '{16'd11,    1'b0, '{1'b0, tdp_pkg::VERDICT_SMALL, 8'd0}},
      '{16'd65521, 1'b0, '{1'b0, tdp_pkg::VERDICT_SMALL, 8'd0}},
      '{16'd63001, 1'b0, '{1'b0, tdp_pkg::VERDICT_SMALL, 8'd0}},
      '{16'd64507, 1'b0, '{1'b0, tdp_pkg::VERDICT_SMALL, 8'd0}},
      '{16'd64009, 1'b0, '{1'b0, tdp_pkg::VERDICT_SMALL, 8'd0}},
      '{16'd32767, 1'b0, '{1'b0, tdp_pkg::VERDICT_SMALL, 8'd0}},
      '{16'd32769, 1'b0, '{1'b0, tdp_pkg::VERDICT_SMALL, 8'd0}},
      '{16'd21845, 1'b0, '{1'b0, tdp_pkg::VERDICT_SMALL, 8'd0}},
      '{16'd43690, 1'b0, '{1'b0, tdp_pkg::VERDICT_SMALL, 8'd0}},
      '{16'd32768, 1'b0, '{1'b0, tdp_pkg::VERDICT_SMALL, 8'd0}}
   };

   trial_division_prime_test u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_prime_flag       (rsp_prime_flag),
      .rsp_verdict          (rsp_verdict),
      .rsp_smallest_divisor (rsp_smallest_divisor)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Classify one value by trial division: below two, even, then odd
   // divisors from three while the divisor squared still fits the value.
   function automatic prime_result_type classify_value(input logic [REQ_WIDTH-1:0] value);
      prime_result_type result;
      int unsigned      n;
      int unsigned      d;
      bit               found;
      result = '{1'b0, tdp_pkg::VERDICT_SMALL, '0};
      n = value;
      found = 1'b0;
      if (n < 2) begin
         result.verdict = tdp_pkg::VERDICT_SMALL;
      end else if (!value[0]) begin
         if (n == 2) begin
            result.prime_flag = 1'b1;
            result.verdict = tdp_pkg::VERDICT_PRIME;
         end else begin
            result.verdict = tdp_pkg::VERDICT_EVEN;
            result.smallest_divisor = 8'd2;
         end
      end else begin
         d = 3;
         while (!found && d * d <= n) begin
            if (n % d == 0) begin
               found = 1'b1;
            end else begin
               d = d + 2;
            end
         end
         if (found) begin
            result.verdict = tdp_pkg::VERDICT_ODD;
            result.smallest_divisor = d[DIVISOR_OUT_WIDTH-1:0];
         end else begin
            result.prime_flag = 1'b1;
            result.verdict = tdp_pkg::VERDICT_PRIME;
         end
      end
      return result;
   endfunction

   // Draw a test value: mostly full-range and odd values, where the
   // divisor loop runs long, plus small values and built odd composites.
   function automatic logic [REQ_WIDTH-1:0] pick_value();
      int unsigned sel;
      int unsigned a;
      int unsigned b;
      int unsigned hi;
      sel = $urandom_range(99);
      if (sel < 35) begin
         return REQ_WIDTH'($urandom);
      end else if (sel < 65) begin
         return REQ_WIDTH'($urandom) | 16'd1;
      end else if (sel < 80) begin
         return REQ_WIDTH'($urandom_range(300));
      end
      // Odd product a * b with a <= b, so a bounds the smallest factor.
      a = 2 * $urandom_range(127, 1) + 1;
      hi = 65535 / a;
      b = $urandom_range(hi, a) | 1;
      if (b > hi) begin
         b = b - 2;
      end
      return REQ_WIDTH'(a * b);
   endfunction

   // Offer one word on the req channel and hold it until it is taken.
   // Drop valid for random idle cycles first; never lower valid and raise
   // it again in the same step.
   task automatic send_word(input logic [REQ_WIDTH-1:0] value, input prime_result_type want);
      pending_query_type query;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      query.value = value;
      query.want = want;
      pending_verdicts.push_back(query);
   endtask

   // Run a batch of random words under the current idle setting.
   task automatic send_random_words(input int unsigned count);
      logic [REQ_WIDTH-1:0] value;
      repeat (count) begin
         value = pick_value();
         send_word(value, classify_value(value));
      end
   endtask

   // Stall the rsp channel at random; redraw every cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Compare every accepted rsp word with the oldest pending query.
   always @(posedge clock) begin : rsp_check
      pending_query_type query;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_verdicts.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
               $display("rsp word with nothing pending: flag %0b verdict %0d divisor %0d",
                        rsp_prime_flag, rsp_verdict, rsp_smallest_divisor);
            end
         end else begin
            query = pending_verdicts.pop_front();
            if (rsp_prime_flag !== query.want.prime_flag
                || rsp_verdict !== query.want.verdict
                || rsp_smallest_divisor !== query.want.smallest_divisor) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS) begin
                  $display("value %0d: want flag %0b verdict %0d divisor %0d, got %0b %0d %0d",
                           query.value, query.want.prime_flag, query.want.verdict,
                           query.want.smallest_divisor, rsp_prime_flag, rsp_verdict,
                           rsp_smallest_divisor);
               end
            end
         end
      end
   end

   // Main sequence: reset, directed table, then random words in four idling settings.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Phase: no idling on either side; walk the directed table, then random words.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < PROBE_ROWS; i++) begin
         send_word(probe_table[i].value,
                   probe_table[i].typed ? probe_table[i].want
                                        : classify_value(probe_table[i].value));
      end
      send_random_words(64);

      // Phase: sender mostly idle.
      send_idle_pct = 80;
      recv_stall_pct = 0;
      send_random_words(68);

      // Phase: receiver mostly stalling.
      send_idle_pct = 0;
      recv_stall_pct = 80;
      send_random_words(68);

      // Phase: both sides idle a third of the time.
      send_idle_pct = 34;
      recv_stall_pct = 34;
      send_random_words(68);

      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) begin
         @(posedge clock);
      end
      // Hold a little longer to catch any stray rsp word.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0 && pending_verdicts.size() == 0) begin
         $display("tb_trial_division_prime_test: PASS");
      end else begin
         $display("tb_trial_division_prime_test: FAIL");
      end
      $finish;
   end

   // Timeout: several times the slowest legal run, every word a large prime.
   initial begin
      #30_000_000;
      $display("tb_trial_division_prime_test: FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/tdp_pkg.sv
hw/rtl/tdp_divider.sv
hw/rtl/trial_division_prime_test.sv
hw/rtl/tdp_checker.sv
tb/tb_trial_division_prime_test.sv
